FILE: rtl/mecodo_pkg.sv
// Package with the payload types, controller commands, constants and arithmetic helpers.
`default_nettype none
package mecodo_pkg;

  // Number of CORDIC iterations for the sine and cosine of the heading.
  localparam int unsigned ANGLE_STEPS = 24;
  localparam int unsigned ITER_W = 5;
  localparam logic [ITER_W-1:0] CORD_LAST = ITER_W'(ANGLE_STEPS - 1);
  localparam logic [ITER_W-1:0] KIN_LAST  = ITER_W'(2);
  localparam logic [ITER_W-1:0] POSE_LAST = ITER_W'(9);

  localparam logic [15:0] INV_SQRT2_Q16   = 16'd46341;
  localparam logic [29:0] INV_TWO_PI_Q32  = 30'd683565276;
  localparam logic [32:0] CORDIC_GAIN_Q30 = 33'h026DD3B6A;
  localparam logic [23:0] TURN_GAIN_RESET = 24'd190055;

  typedef struct packed {
    logic signed [31:0] wheel_front_left;
    logic signed [31:0] wheel_front_right;
    logic signed [31:0] wheel_back_right;
    logic signed [31:0] wheel_back_left;
    logic [15:0]        elapsed_time;
  } in_t;

  typedef struct packed {
    logic signed [47:0] position_x;
    logic signed [47:0] position_y;
    logic [31:0]        heading_angle;
    logic signed [31:0] body_velocity_x;
    logic signed [31:0] body_velocity_y;
    logic signed [31:0] turn_rate;
  } out_t;

  // Datapath operations, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE, OP_M_VX, OP_M_VY, OP_M_W, OP_CORDIC, OP_M_XC, OP_M_YS, OP_M_XS,
    OP_M_YC, OP_M_XDT, OP_M_YDT, OP_M_WDT, OP_M_HLO, OP_M_HHI, OP_HEAD
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [ITER_W-1:0] iter;
    logic             load;
    logic             out_load;
  } cmd_t;

  // Arctangent of 2^-i as a binary angle in Q0.32 turns scale.
  function automatic logic [31:0] atan_lut(input logic [ITER_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // Right shift that rounds to nearest, ties away from zero.
  function automatic logic signed [69:0] rnd_away(input logic signed [69:0] v,
                                                  input int unsigned s);
    logic [69:0] mag;
    mag = v[69] ? 70'(-v) : 70'(v);
    mag = (mag + (70'd1 << (s - 1))) >> s;
    return v[69] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    logic signed [31:0] r;
    if (v > 70'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -70'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [69:0] v);
    logic signed [47:0] r;
    if (v > 70'sd140737488355327) r = 48'sh7FFFFFFFFFFF;
    else if (v < -70'sd140737488355328) r = 48'sh800000000000;
    else r = v[47:0];
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/mecodo_ctrl.sv
// Controller state machine that sequences the shared multiplier and CORDIC steps.
`default_nettype none
module mecodo_ctrl import mecodo_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_KIN    = 5'b00010,
    ST_CORDIC = 5'b00100,
    ST_POSE   = 5'b01000,
    ST_OUT    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Next state, step counter and command decode.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op = OP_NONE;
    cmd.iter = cnt_r;
    cmd.load = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_KIN;
          cnt_nxt = '0;
        end
      end
      ST_KIN: begin
        case (cnt_r)
          5'd0: cmd.op = OP_M_VX;
          5'd1: cmd.op = OP_M_VY;
          default: cmd.op = OP_M_W;
        endcase
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == KIN_LAST) begin
          state_nxt = ST_CORDIC;
          cnt_nxt = '0;
        end
      end
      ST_CORDIC: begin
        cmd.op = OP_CORDIC;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CORD_LAST) begin
          state_nxt = ST_POSE;
          cnt_nxt = '0;
        end
      end
      ST_POSE: begin
        case (cnt_r)
          5'd0: cmd.op = OP_M_XC;
          5'd1: cmd.op = OP_M_YS;
          5'd2: cmd.op = OP_M_XS;
          5'd3: cmd.op = OP_M_YC;
          5'd4: cmd.op = OP_M_XDT;
          5'd5: cmd.op = OP_M_YDT;
          5'd6: cmd.op = OP_M_WDT;
          5'd7: cmd.op = OP_M_HLO;
          5'd8: cmd.op = OP_M_HHI;
          default: cmd.op = OP_HEAD;
        endcase
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == POSE_LAST) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_KIN)
    else $error("accepted request did not start the kinematics steps");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_valid_r && !out_ready) |=> state_r == ST_OUT)
    else $error("result overwritten while the previous one was waiting");
  a_out_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result loaded without valid");
`endif

endmodule
`default_nettype wire

FILE: rtl/mecodo_datapath.sv
// Datapath: kinematics, CORDIC rotation, shared multiplier and pose integration.
`default_nettype none
module mecodo_datapath import mecodo_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  input  wire in_t         in_data,
  input  wire logic        cfg_valid,
  input  wire logic [23:0] cfg_data,
  output out_t             out_data
);

  logic [23:0] gain_r;
  logic signed [47:0] pose_x_r, pose_y_r;
  logic [31:0] heading_r;
  logic signed [33:0] sx_r, sy_r, sw_r;
  logic [15:0] dt_r;
  logic signed [31:0] vx_r, vy_r, w_r;
  logic signed [32:0] x_r, y_r;
  logic signed [33:0] z_r;
  logic flip_r;
  logic signed [69:0] prod_r;
  logic signed [64:0] acc_r;
  logic signed [34:0] wx_r, wy_r;
  logic neg_r;
  logic [15:0] hi_r;
  logic [30:0] lop_r;
  out_t out_r;

  logic signed [34:0] ma, mb;
  logic signed [32:0] cos_v, sin_v, dx, dy;
  logic signed [33:0] atan_v;
  logic signed [69:0] ext_fl, ext_fr, ext_br, ext_bl;
  logic signed [69:0] wsum, pose_sum;
  logic [69:0] pmag;
  logic [31:0] hdelta, hcorr;
  logic init_flip;
  logic [31:0] init_a;

  assign out_data = out_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) gain_r <= TURN_GAIN_RESET;
    else if (cfg_valid) gain_r <= cfg_data;
  end

  // Heading quadrant fold and CORDIC outputs.
  assign init_flip = heading_r[31] ^ heading_r[30];
  assign init_a = init_flip ? heading_r + 32'h80000000 : heading_r;
  assign cos_v = flip_r ? -x_r : x_r;
  assign sin_v = flip_r ? -y_r : y_r;
  assign dx = x_r >>> cmd.iter;
  assign dy = y_r >>> cmd.iter;
  assign atan_v = $signed({2'b00, atan_lut(cmd.iter)});

  assign ext_fl = 70'(in_data.wheel_front_left);
  assign ext_fr = 70'(in_data.wheel_front_right);
  assign ext_br = 70'(in_data.wheel_back_right);
  assign ext_bl = 70'(in_data.wheel_back_left);

  // Magnitude of the heading product for the turn-to-angle scaling.
  assign pmag = prod_r[69] ? 70'(-prod_r) : 70'(prod_r);
  assign hdelta = prod_r[31:0] + {1'b0, lop_r};
  assign hcorr = neg_r ? 32'(-hdelta) : hdelta;

  // Multiplier operand selection.
  always_comb begin
    ma = '0;
    mb = '0;
    wsum = '0;
    pose_sum = '0;
    case (cmd.op)
      OP_M_VX:  begin ma = 35'(sx_r); mb = $signed({19'b0, INV_SQRT2_Q16}); end
      OP_M_VY:  begin ma = 35'(sy_r); mb = $signed({19'b0, INV_SQRT2_Q16}); end
      OP_M_W:   begin ma = 35'(sw_r); mb = $signed({11'b0, gain_r}); end
      OP_M_XC:  begin ma = 35'(vx_r); mb = 35'(cos_v); end
      OP_M_YS:  begin ma = 35'(vy_r); mb = 35'(sin_v); end
      OP_M_XS:  begin
        ma = 35'(vx_r); mb = 35'(sin_v);
        wsum = 70'(acc_r) - prod_r;
      end
      OP_M_YC:  begin ma = 35'(vy_r); mb = 35'(cos_v); end
      OP_M_XDT: begin
        ma = wx_r; mb = $signed({19'b0, dt_r});
        wsum = 70'(acc_r) + prod_r;
      end
      OP_M_YDT: begin
        ma = wy_r; mb = $signed({19'b0, dt_r});
        pose_sum = 70'(pose_x_r) + rnd_away(prod_r, 16);
      end
      OP_M_WDT: begin
        ma = 35'(w_r); mb = $signed({19'b0, dt_r});
        pose_sum = 70'(pose_y_r) + rnd_away(prod_r, 16);
      end
      OP_M_HLO: begin
        ma = $signed({3'b0, pmag[31:0]}); mb = $signed({5'b0, INV_TWO_PI_Q32});
      end
      OP_M_HHI: begin ma = $signed({19'b0, hi_r}); mb = $signed({5'b0, INV_TWO_PI_Q32}); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // Pose state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r <= '0;
      pose_y_r <= '0;
      heading_r <= '0;
    end else begin
      if (cmd.op == OP_M_YDT) pose_x_r <= sat48(pose_sum);
      if (cmd.op == OP_M_WDT) pose_y_r <= sat48(pose_sum);
      if (cmd.op == OP_HEAD) heading_r <= heading_r + hcorr;
    end
  end

  // Working registers of one request.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx_r <= 34'(ext_fl - ext_fr - ext_br + ext_bl);
      sy_r <= 34'(ext_fl + ext_fr - ext_br - ext_bl);
      sw_r <= 34'(ext_fl + ext_fr + ext_br + ext_bl);
      dt_r <= in_data.elapsed_time;
      x_r <= $signed(CORDIC_GAIN_Q30);
      y_r <= '0;
      z_r <= 34'($signed(init_a));
      flip_r <= init_flip;
    end
    if (cmd.op != OP_NONE && cmd.op != OP_CORDIC && cmd.op != OP_HEAD) prod_r <= ma * mb;
    case (cmd.op)
      OP_M_VY: vx_r <= sat32(rnd_away(prod_r, 16));
      OP_M_W:  vy_r <= sat32(rnd_away(prod_r, 16));
      OP_CORDIC: begin
        w_r <= sat32(rnd_away(prod_r, 16));
        if (!z_r[33]) begin
          x_r <= x_r - dy;
          y_r <= y_r + dx;
          z_r <= z_r - atan_v;
        end else begin
          x_r <= x_r + dy;
          y_r <= y_r - dx;
          z_r <= z_r + atan_v;
        end
      end
      OP_M_YS:  acc_r <= prod_r[64:0];
      OP_M_XS:  wx_r <= 35'(rnd_away(wsum, 30));
      OP_M_YC:  acc_r <= prod_r[64:0];
      OP_M_XDT: wy_r <= 35'(rnd_away(wsum, 30));
      OP_M_HLO: begin
        neg_r <= prod_r[69];
        hi_r <= pmag[47:32];
      end
      OP_M_HHI: lop_r <= 31'((prod_r + 70'sd2147483648) >>> 32);
      default: ;
    endcase
    if (cmd.out_load) begin
      out_r.position_x <= pose_x_r;
      out_r.position_y <= pose_y_r;
      out_r.heading_angle <= heading_r;
      out_r.body_velocity_x <= vx_r;
      out_r.body_velocity_y <= vy_r;
      out_r.turn_rate <= w_r;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mecanum_odometry_integrator.sv
// Top level of the mecanum wheel odometry integrator.
// One request at a time: a new one is taken once the result is loaded for output.
// A finished result waits in the output register while the next request is accepted.
// Reset (rst_n, synchronous) clears the pose and heading and sets turn_gain to 190055.
`default_nettype none
module mecanum_odometry_integrator import mecodo_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [23:0] cfg_data
);

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  // Sequencer.
  mecodo_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
  );

  // Arithmetic and pose state.
  mecodo_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_data(in_data),
    .cfg_valid(cfg_valid), .cfg_data(cfg_data), .out_data(out_data)
  );

endmodule
`default_nettype wire
